// ----- rtl/bxd_pkg.sv -----
// Shared constants, register codes and state types of the box-area downscaler.
package bxd_pkg;

  // Pixel and accumulator sizes.
  localparam int PIX_W   = 8;
  localparam int SUM_W   = 24;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Output coordinate width.
  localparam int XY_W = 10;

  // Vertical limits, which follow from the fixed register widths.
  localparam int SRC_H_MAX = 4096;
  localparam int H_W       = 13;
  localparam int ROWC_W    = 12;
  localparam int OUT_H_MAX = 1024;
  localparam int OH_W      = 11;
  localparam int BR_W      = 10;

  // Horizontal output cap that applies whatever the parameters are.
  localparam int OUT_W_CAP = 1024;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SRC_SIZE_W = 13;
  localparam int OUT_SIZE_W = 11;
  localparam int DEF_SIZE   = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3
  } cfg_reg_e;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_OUT_WIDTH = 1024;
  localparam int DEF_MAX_SRC_WIDTH = 4096;

  // Words that may wait between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    F_SETUP,
    F_DIVW,
    F_DIVH,
    F_IDLE,
    F_ACC
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_START,
    B_DIV
  } back_state_t;

endpackage

// ----- rtl/bxd_pix_if.sv -----
// Input channel carrying one source pixel per word.
interface bxd_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bxd_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

// ----- rtl/bxd_out_if.sv -----
// Output channel carrying one averaged pixel and its coordinates per word.
interface bxd_out_if;
  logic                      valid;
  logic                      ready;
  logic [bxd_pkg::PIX_W-1:0] avg_pixel;
  logic [bxd_pkg::XY_W-1:0]  out_x;
  logic [bxd_pkg::XY_W-1:0]  out_y;
  logic                      frame_last;

  modport source (output valid, output avg_pixel, output out_x, output out_y,
                  output frame_last, input ready);
  modport sink (input valid, input avg_pixel, input out_x, input out_y,
                input frame_last, output ready);
endinterface

// ----- rtl/bxd_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface bxd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bxd_pkg::CFG_IDX_W-1:0]  index;
  logic [bxd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/box_area_downscaler.sv -----
// Top level of the box-area image downscaler for one 8-bit plane.
//
// Usage: source pixels enter on pix_in in raster order, one per word. Each
// output pixel is the rounded mean of its rectangular source bin and leaves
// on avg_out with its output column and row; frame_last marks the final
// output pixel of a frame, after which the position counters wrap.
// Sizes are written on cfg (index 0 source width, 1 source height, 2 output
// width, 3 output height); any write to those restarts the frame. Write
// only while the block is idle.
// Throughput: the front takes a pixel and then does the read-modify-write of
// the column accumulator RAM before it takes another. A finished bin costs the
// back an area multiply plus a serial division of one quotient bit per cycle,
// through a 4-word queue; bins finish at most once per bin width, so the queue
// absorbs them unless bins are very narrow and short.
// After reset and after each size write, pix_in stays not ready while the bin
// step sizes are divided out.
// When the receiver stalls, the result waits in the output register, the
// queue fills and pix_in then drops ready; nothing is lost.
module box_area_downscaler #(
  parameter int MAX_OUT_WIDTH = bxd_pkg::DEF_MAX_OUT_WIDTH,
  parameter int MAX_SRC_WIDTH = bxd_pkg::DEF_MAX_SRC_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  bxd_pix_if.sink   pix_in,
  bxd_out_if.source avg_out,
  bxd_cfg_if.sink   cfg
);

  localparam int SW = $clog2(MAX_SRC_WIDTH + 1);
  localparam int QW = bxd_pkg::SUM_W + SW + bxd_pkg::H_W + 2 * bxd_pkg::XY_W + 1;

  logic          q_push, q_full, q_pop, q_empty;
  logic [QW-1:0] q_wdata, q_rdata;

  bxd_front #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_SRC_WIDTH (MAX_SRC_WIDTH),
    .QW            (QW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .pix_in (pix_in),
    .cfg    (cfg),
    .q_push (q_push),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  bxd_queue #(.WIDTH(QW), .DEPTH(bxd_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  bxd_back #(.SW(SW), .QW(QW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .avg_out (avg_out)
  );

endmodule

// ----- rtl/bxd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bxd_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module bxd_div #(
  parameter int NW = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    den_r;
  logic [DW:0]      rem_sh;
  logic [DW+1:0]    diff;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    rem_sh = {rem, quo[NW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (!diff[DW+1]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ----- rtl/bxd_queue.sv -----
// Small first-in first-out queue of packed words between front and back.
module bxd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/bxd_front.sv -----
// Front part: configuration, bin tracking and column accumulation.
module bxd_front #(
  parameter int MAX_OUT_WIDTH = bxd_pkg::DEF_MAX_OUT_WIDTH,
  parameter int MAX_SRC_WIDTH = bxd_pkg::DEF_MAX_SRC_WIDTH,
  parameter int QW            = 64
) (
  input  logic          clk,
  input  logic          rst,
  bxd_pix_if.sink       pix_in,
  bxd_cfg_if.sink       cfg,
  output logic          q_push,
  output logic [QW-1:0] q_data,
  input  logic          q_full
);

  localparam int SW   = $clog2(MAX_SRC_WIDTH + 1);
  localparam int CW   = $clog2(MAX_SRC_WIDTH);
  localparam int LIMW = (MAX_OUT_WIDTH < bxd_pkg::OUT_W_CAP) ? MAX_OUT_WIDTH
                                                             : bxd_pkg::OUT_W_CAP;
  localparam int OWW  = $clog2(LIMW + 1);
  localparam int BCW  = $clog2(MAX_OUT_WIDTH);
  localparam int DNW  = (SW > bxd_pkg::H_W) ? SW : bxd_pkg::H_W;
  localparam int DDW  = (OWW > bxd_pkg::OH_W) ? OWW : bxd_pkg::OH_W;
  localparam int HW   = bxd_pkg::H_W;
  localparam int OHW  = bxd_pkg::OH_W;
  localparam int SUMW = bxd_pkg::SUM_W;

  bxd_pkg::front_state_t state, state_next;

  // Configuration registers.
  logic [bxd_pkg::SRC_SIZE_W-1:0] src_width, src_height;
  logic [bxd_pkg::OUT_SIZE_W-1:0] out_width, out_height;
  logic                           restart;

  // Effective sizes and bin steps.
  logic [SW-1:0]  eff_sw, eff_sw_c, q_w;
  logic [OWW-1:0] eff_ow, eff_ow_c, lim_w_c, r_w, rem_w;
  logic [HW-1:0]  eff_sh, eff_sh_c, q_h;
  logic [OHW-1:0] eff_oh, eff_oh_c, lim_h_c, r_h, rem_h;

  // Position and bin bounds.
  logic [CW-1:0]                 src_col;
  logic [bxd_pkg::ROWC_W-1:0]    src_row;
  logic [BCW-1:0]                bin_col;
  logic [bxd_pkg::BR_W-1:0]      bin_row;
  logic [SW-1:0]                 col_start, col_end;
  logic [HW-1:0]                 row_start, row_end;
  logic [bxd_pkg::PIX_W-1:0]     pix_r;

  // Divider for the bin steps.
  logic           div_start, div_done;
  logic [DNW-1:0] div_num, div_quo;
  logic [DDW-1:0] div_den, div_rem;

  // Accumulator RAM.
  logic [SUMW-1:0] ram_rdata, acc;
  logic [SUMW:0]   sum_c;

  // Per-pixel decisions.
  logic            first, col_last, row_last, bin_done, frame_last;
  logic [SW-1:0]   col_next1;
  logic [HW-1:0]   row_next1;
  logic [OWW:0]    rem_w_sum;
  logic [OHW:0]    rem_h_sum;
  logic            w_carry, h_carry;
  logic            accept;

  assign accept     = pix_in.valid && pix_in.ready;
  assign cfg.ready  = 1'b1;

  // Configuration writes; any known register restarts the frame.
  always_comb begin
    restart = 1'b0;
    if (cfg.valid) begin
      unique case (cfg.index)
        bxd_pkg::REG_SRC_WIDTH, bxd_pkg::REG_SRC_HEIGHT,
        bxd_pkg::REG_OUT_WIDTH, bxd_pkg::REG_OUT_HEIGHT: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bxd_pkg::SRC_SIZE_W'(bxd_pkg::DEF_SIZE);
      src_height <= bxd_pkg::SRC_SIZE_W'(bxd_pkg::DEF_SIZE);
      out_width  <= bxd_pkg::OUT_SIZE_W'(bxd_pkg::DEF_SIZE);
      out_height <= bxd_pkg::OUT_SIZE_W'(bxd_pkg::DEF_SIZE);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bxd_pkg::REG_SRC_WIDTH:  src_width  <= cfg.data[bxd_pkg::SRC_SIZE_W-1:0];
        bxd_pkg::REG_SRC_HEIGHT: src_height <= cfg.data[bxd_pkg::SRC_SIZE_W-1:0];
        bxd_pkg::REG_OUT_WIDTH:  out_width  <= cfg.data[bxd_pkg::OUT_SIZE_W-1:0];
        bxd_pkg::REG_OUT_HEIGHT: out_height <= cfg.data[bxd_pkg::OUT_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the requested sizes to what the block supports.
  always_comb begin
    if (src_width == '0) begin
      eff_sw_c = SW'(1);
    end else if (32'(src_width) > MAX_SRC_WIDTH) begin
      eff_sw_c = SW'(MAX_SRC_WIDTH);
    end else begin
      eff_sw_c = SW'(src_width);
    end
    lim_w_c = (32'(eff_sw_c) < LIMW) ? OWW'(eff_sw_c) : OWW'(LIMW);
    if (out_width == '0) begin
      eff_ow_c = OWW'(1);
    end else if (32'(out_width) > 32'(lim_w_c)) begin
      eff_ow_c = lim_w_c;
    end else begin
      eff_ow_c = OWW'(out_width);
    end
    if (src_height == '0) begin
      eff_sh_c = HW'(1);
    end else if (32'(src_height) > bxd_pkg::SRC_H_MAX) begin
      eff_sh_c = HW'(bxd_pkg::SRC_H_MAX);
    end else begin
      eff_sh_c = HW'(src_height);
    end
    lim_h_c = (32'(eff_sh_c) < bxd_pkg::OUT_H_MAX) ? OHW'(eff_sh_c)
                                                  : OHW'(bxd_pkg::OUT_H_MAX);
    if (out_height == '0) begin
      eff_oh_c = OHW'(1);
    end else if (32'(out_height) > 32'(lim_h_c)) begin
      eff_oh_c = lim_h_c;
    end else begin
      eff_oh_c = OHW'(out_height);
    end
  end

  bxd_div #(.NW(DNW), .DW(DDW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  bxd_ram #(.WIDTH(SUMW), .DEPTH(MAX_OUT_WIDTH)) u_sums (
    .clk   (clk),
    .we    (state == bxd_pkg::F_ACC),
    .waddr (bin_col),
    .wdata (acc),
    .raddr (bin_col),
    .rdata (ram_rdata)
  );

  // Decisions for the pixel in hand.
  always_comb begin
    first      = (HW'(src_row) == row_start) && (SW'(src_col) == col_start);
    col_next1  = SW'(src_col) + SW'(1);
    row_next1  = HW'(src_row) + HW'(1);
    col_last   = (col_next1 >= col_end);
    row_last   = (row_next1 >= row_end);
    bin_done   = col_last && row_last;
    frame_last = ((OWW'(bin_col) + OWW'(1)) == eff_ow) &&
                 ((OHW'(bin_row) + OHW'(1)) == eff_oh);
    sum_c      = {1'b0, ram_rdata} + (SUMW + 1)'(pix_r);
    if (first) begin
      acc = SUMW'(pix_r);
    end else if (sum_c[SUMW]) begin
      acc = bxd_pkg::SUM_MAX;
    end else begin
      acc = sum_c[SUMW-1:0];
    end
    rem_w_sum = {1'b0, rem_w} + {1'b0, r_w};
    rem_h_sum = {1'b0, rem_h} + {1'b0, r_h};
    w_carry   = (rem_w_sum >= {1'b0, eff_ow});
    h_carry   = (rem_h_sum >= {1'b0, eff_oh});
  end

  assign q_data = {acc, col_end - col_start, row_end - row_start,
                   bxd_pkg::XY_W'(bin_col), bxd_pkg::XY_W'(bin_row), frame_last};

  // Sequencer: setup divisions, then one pixel per accept and accumulate pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bxd_pkg::F_SETUP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_num      = DNW'(eff_sw_c);
    div_den      = DDW'(eff_ow_c);
    pix_in.ready = 1'b0;
    q_push       = 1'b0;
    unique case (state)
      bxd_pkg::F_SETUP: begin
        div_start  = 1'b1;
        state_next = bxd_pkg::F_DIVW;
      end
      bxd_pkg::F_DIVW: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = DNW'(eff_sh);
          div_den    = DDW'(eff_oh);
          state_next = bxd_pkg::F_DIVH;
        end
      end
      bxd_pkg::F_DIVH: begin
        if (div_done) begin
          state_next = bxd_pkg::F_IDLE;
        end
      end
      bxd_pkg::F_IDLE: begin
        pix_in.ready = !q_full;
        if (pix_in.valid && !q_full) begin
          state_next = bxd_pkg::F_ACC;
        end
      end
      bxd_pkg::F_ACC: begin
        q_push     = bin_done;
        state_next = bxd_pkg::F_IDLE;
      end
      default: state_next = bxd_pkg::F_SETUP;
    endcase
    if (restart) begin
      state_next = bxd_pkg::F_SETUP;
    end
  end

  // Size, step and position registers.
  always_ff @(posedge clk) begin
    unique case (state)
      bxd_pkg::F_SETUP: begin
        eff_sw <= eff_sw_c;
        eff_ow <= eff_ow_c;
        eff_sh <= eff_sh_c;
        eff_oh <= eff_oh_c;
      end
      bxd_pkg::F_DIVW: begin
        if (div_done) begin
          q_w <= SW'(div_quo);
          r_w <= OWW'(div_rem);
        end
      end
      bxd_pkg::F_DIVH: begin
        if (div_done) begin
          q_h       <= HW'(div_quo);
          r_h       <= OHW'(div_rem);
          src_col   <= '0;
          src_row   <= '0;
          bin_col   <= '0;
          bin_row   <= '0;
          col_start <= '0;
          row_start <= '0;
          col_end   <= q_w;
          rem_w     <= r_w;
          row_end   <= HW'(div_quo);
          rem_h     <= OHW'(div_rem);
        end
      end
      bxd_pkg::F_IDLE: begin
        if (accept) begin
          pix_r <= pix_in.pixel;
        end
      end
      bxd_pkg::F_ACC: begin
        if (col_next1 >= eff_sw) begin
          // End of a source line: back to the first column bin.
          src_col   <= '0;
          bin_col   <= '0;
          col_start <= '0;
          col_end   <= q_w;
          rem_w     <= r_w;
          if (row_next1 >= eff_sh) begin
            src_row   <= '0;
            bin_row   <= '0;
            row_start <= '0;
            row_end   <= q_h;
            rem_h     <= r_h;
          end else begin
            src_row <= src_row + bxd_pkg::ROWC_W'(1);
            if (row_last && ((OHW'(bin_row) + OHW'(1)) < eff_oh)) begin
              bin_row   <= bin_row + bxd_pkg::BR_W'(1);
              row_start <= row_end;
              row_end   <= row_end + q_h + HW'(h_carry);
              rem_h     <= h_carry ? OHW'(rem_h_sum - {1'b0, eff_oh})
                                   : OHW'(rem_h_sum);
            end
          end
        end else begin
          src_col <= src_col + CW'(1);
          if (col_last && ((OWW'(bin_col) + OWW'(1)) < eff_ow)) begin
            bin_col   <= bin_col + BCW'(1);
            col_start <= col_end;
            col_end   <= col_end + q_w + SW'(w_carry);
            rem_w     <= w_carry ? OWW'(rem_w_sum - {1'b0, eff_ow})
                                 : OWW'(rem_w_sum);
          end
        end
      end
      default: ;
    endcase
  end

  // The queue always has room for the word of a pixel that was taken.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  // A taken pixel is accumulated in the very next cycle.
  a_accept_acc: assert property (@(posedge clk) disable iff (rst)
    (accept && !restart) |=> (state == bxd_pkg::F_ACC))
    else $error("accepted pixel not accumulated");

  // The current column bin always lies inside the output width.
  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    (state == bxd_pkg::F_ACC) |-> (32'(bin_col) < 32'(eff_ow)))
    else $error("column bin beyond output width");

endmodule

// ----- rtl/bxd_back.sv -----
// Back part: bin area, rounded mean by serial division, output register.
module bxd_back #(
  parameter int SW = 13,
  parameter int QW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  bxd_out_if.source     avg_out
);

  localparam int HW  = bxd_pkg::H_W;
  localparam int AW  = SW + HW;
  localparam int NW  = ((bxd_pkg::SUM_W > AW) ? bxd_pkg::SUM_W : AW) + 1;
  localparam int XYW = bxd_pkg::XY_W;

  bxd_pkg::back_state_t state, state_next;

  logic [bxd_pkg::SUM_W-1:0] acc_r;
  logic [SW-1:0]             cw_r;
  logic [HW-1:0]             rh_r;
  logic [XYW-1:0]            x_r, y_r;
  logic                      last_r;
  logic [AW-1:0]             area_r;
  logic                      div_start, div_done, load;
  logic [NW-1:0]             div_num, div_quo;
  logic [AW-1:0]             div_rem;
  logic                      done_held;

  assign div_num = NW'(acc_r) + NW'(area_r >> 1);

  bxd_div #(.NW(NW), .DW(AW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (area_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bxd_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Take a word, form the area, divide, then hand over to the output register.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    unique case (state)
      bxd_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = bxd_pkg::B_MUL;
        end
      end
      bxd_pkg::B_MUL: state_next = bxd_pkg::B_START;
      bxd_pkg::B_START: begin
        div_start  = 1'b1;
        state_next = bxd_pkg::B_DIV;
      end
      bxd_pkg::B_DIV: begin
        if ((div_done || done_held) && (!avg_out.valid || avg_out.ready)) begin
          load       = 1'b1;
          state_next = bxd_pkg::B_IDLE;
        end
      end
      default: state_next = bxd_pkg::B_IDLE;
    endcase
  end

  // Word held while it is worked on.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      {acc_r, cw_r, rh_r, x_r, y_r, last_r} <= q_data;
    end
    if (state == bxd_pkg::B_MUL) begin
      area_r <= AW'(cw_r) * AW'(rh_r);
    end
  end

  // The division's done flag is held here until the output register is free; the quotient stays in the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      done_held <= 1'b0;
    end else if (div_done && !load) begin
      done_held <= 1'b1;
    end else if (state != bxd_pkg::B_DIV || load) begin
      done_held <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_out.valid <= 1'b0;
    end else if (load) begin
      avg_out.valid <= 1'b1;
    end else if (avg_out.ready) begin
      avg_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      avg_out.avg_pixel  <= div_quo[bxd_pkg::PIX_W-1:0];
      avg_out.out_x      <= x_r;
      avg_out.out_y      <= y_r;
      avg_out.frame_last <= last_r;
    end
  end

endmodule
